// ----- src/hash_set_insert_find_macros.svh -----
// ----------------------------------------------------------------------------
// hash set assertion macros
// concurrent check wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef HASH_SET_INSERT_FIND_MACROS_SVH
`define HASH_SET_INSERT_FIND_MACROS_SVH

`ifndef SYNTHESIS

// implication or plain property, checked out of reset
`define HSIF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold out of reset
`define HSIF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define HSIF_ASSERT(lbl, clk, rst_n, prop, msg)
`define HSIF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- src/hsif_pkg.sv -----
// ----------------------------------------------------------------------------
// hsif_pkg
// shared field widths, stream packing and command codes of the hash set
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsif_pkg;

    // command codes carried on tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    // input field widths
    localparam int CHAR_W      = 8;
    localparam int KEY_FIELD_W = 64;
    localparam int LEN_FIELD_W = 4;

    // input tdata: key_chars, key_length, zero pad to whole bytes
    localparam int IN_KEY_LSB = 0;
    localparam int IN_LEN_LSB = KEY_FIELD_W;
    localparam int IN_TDATA_W = ((KEY_FIELD_W + LEN_FIELD_W + 7) / 8) * 8;

    // output tdata: found, bucket_full, zero pad
    localparam int OUT_FOUND_BIT = 0;
    localparam int OUT_FULL_BIT  = 1;
    localparam int OUT_TDATA_W   = 8;

    // hash word and bucket reduction
    localparam int HASH_W       = 32;
    localparam int REDUCE_BITS  = 4;
    localparam int REDUCE_STEPS = HASH_W / REDUCE_BITS;
    localparam int STEP_W       = $clog2(REDUCE_STEPS);

endpackage

// ----- src/hsif_ram.sv -----
// ----------------------------------------------------------------------------
// hsif_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsif_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/hsif_hash.sv -----
// ----------------------------------------------------------------------------
// hsif_hash
// iterative key hash, one character a cycle, then reduction to a bucket
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsif_hash #(
    parameter int BUCKETS       = 1024,
    parameter int MAX_KEY_CHARS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [8*MAX_KEY_CHARS-1:0]         i_chars,
    input  logic [$clog2(MAX_KEY_CHARS+1)-1:0] i_len,
    output logic                               o_done,
    output logic [$clog2(BUCKETS)-1:0]         o_bucket
);

    import hsif_pkg::*;

    localparam int KEY_W    = CHAR_W * MAX_KEY_CHARS;
    localparam int LEN_W    = $clog2(MAX_KEY_CHARS + 1);
    localparam int BUCKET_W = $clog2(BUCKETS);
    localparam bit IS_POW2  = (BUCKETS & (BUCKETS - 1)) == 0;
    localparam logic [BUCKET_W:0] BUCKETS_C = (BUCKET_W + 1)'(BUCKETS);

    typedef enum logic [1:0] {
        H_IDLE,
        H_MIX,
        H_REDUCE
    } t_hash_state;

    t_hash_state          r_state;
    logic [HASH_W-1:0]    r_h;
    logic [KEY_W-1:0]     r_chars;
    logic [LEN_W-1:0]     r_len;
    logic [LEN_W-1:0]     r_i;
    logic [BUCKET_W-1:0]  r_rem;
    logic [STEP_W-1:0]    r_step;
    logic                 r_done;
    logic [BUCKET_W-1:0]  r_bucket;

    logic [CHAR_W-1:0]    w_char;
    logic [HASH_W-1:0]    w_mix;
    logic [BUCKET_W-1:0]  n_rem;
    logic [HASH_W-1:0]    n_h_shift;

    // one mixing step: h * c + c + i, modulo 2^32
    assign w_char = r_chars[CHAR_W-1:0];
    assign w_mix  = HASH_W'(r_h * HASH_W'(w_char)) + HASH_W'(w_char) + HASH_W'(r_i);

    // restoring reduction, REDUCE_BITS hash bits per step from the top down
    always_comb begin
        logic [BUCKET_W:0]   t;
        logic [BUCKET_W-1:0] rem;
        logic [HASH_W-1:0]   h;
        rem = r_rem;
        h   = r_h;
        for (int b = 0; b < REDUCE_BITS; b++) begin
            t = {rem, h[HASH_W-1]};
            h = {h[HASH_W-2:0], 1'b0};
            if (t >= BUCKETS_C) begin
                t = t - BUCKETS_C;
            end
            rem = t[BUCKET_W-1:0];
        end
        n_rem     = rem;
        n_h_shift = h;
    end

    // sequencer: mix all characters, then reduce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_h     <= '0;
                        r_chars <= i_chars;
                        r_len   <= i_len;
                        r_i     <= '0;
                        r_state <= H_MIX;
                    end
                end
                H_MIX: begin
                    if (r_i == r_len) begin
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_state <= H_REDUCE;
                    end else begin
                        r_h     <= w_mix;
                        r_chars <= r_chars >> CHAR_W;
                        r_i     <= r_i + LEN_W'(1);
                    end
                end
                H_REDUCE: begin
                    if (IS_POW2) begin
                        r_bucket <= r_h[BUCKET_W-1:0];
                        r_done   <= 1'b1;
                        r_state  <= H_IDLE;
                    end else begin
                        r_rem  <= n_rem;
                        r_h    <= n_h_shift;
                        r_step <= r_step + STEP_W'(1);
                        if (r_step == STEP_W'(REDUCE_STEPS - 1)) begin
                            r_bucket <= n_rem;
                            r_done   <= 1'b1;
                            r_state  <= H_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= H_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_bucket;

endmodule

// ----- src/hash_set_insert_find.sv -----
// ----------------------------------------------------------------------------
// hash_set_insert_find
// bucketed hash set of short byte-string keys with insert and find commands
// ----------------------------------------------------------------------------
// One command is in flight at a time. After acceptance the key is hashed one
// character per cycle with one multiply each, the hash is reduced to a bucket
// (its low bits when BUCKETS is a power of two, otherwise a restoring remainder
// taken four hash bits per step), then the bucket row is read from the table
// ram and, in S_CHECK, compared across all ways; an insert of a new key into a
// free way writes the row back in that same cycle. tready rises again once
// the result sits in the output register. After reset the table is cleared
// one bucket per cycle, and no command is accepted until clearing is done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "hash_set_insert_find_macros.svh"

module hash_set_insert_find #(
    parameter int BUCKETS       = 1024,
    parameter int WAYS          = 4,
    parameter int MAX_KEY_CHARS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [hsif_pkg::IN_TDATA_W-1:0]  i_s_tdata,  // key_chars, key_length, pad
    input  logic                             i_s_tuser,  // cmd
    // result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [hsif_pkg::OUT_TDATA_W-1:0] o_m_tdata   // found, bucket_full, pad
);

    import hsif_pkg::*;

    localparam int KEY_W    = CHAR_W * MAX_KEY_CHARS;
    localparam int LEN_W    = $clog2(MAX_KEY_CHARS + 1);
    localparam int BUCKET_W = $clog2(BUCKETS);
    localparam int WAY_W    = 1 + LEN_W + KEY_W;
    localparam int ROW_W    = WAYS * WAY_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_CHECK,
        S_OUT
    } t_state;

    t_state                          r_state;
    logic [BUCKET_W-1:0]             r_clr_addr;
    logic                            r_cmd;
    logic [KEY_W-1:0]                r_key;
    logic [LEN_W-1:0]                r_len;
    logic [BUCKET_W-1:0]             r_bucket;
    logic                            r_res_found;
    logic                            r_res_full;
    logic                            r_m_valid;
    logic                            r_m_found;
    logic                            r_m_full;

    logic                            w_accept;
    logic [LEN_FIELD_W-1:0]          w_len_in;
    logic [LEN_FIELD_W-1:0]          w_len_sat;
    logic [LEN_W-1:0]                w_len;
    logic [KEY_W-1:0]                w_key;
    logic                            w_hash_done;
    logic [BUCKET_W-1:0]             w_hash_bucket;
    logic                            w_rd_en;
    logic                            w_wr_en;
    logic [BUCKET_W-1:0]             w_wr_addr;
    logic [ROW_W-1:0]                w_wr_data;
    logic [ROW_W-1:0]                w_rd_data;
    logic [WAYS-1:0][WAY_W-1:0]      w_row;
    logic [WAYS-1:0][WAY_W-1:0]      w_new_row;
    logic [WAYS-1:0]                 w_hit;
    logic [WAYS-1:0]                 w_free_oh;
    logic                            w_found;
    logic                            w_has_free;
    logic                            w_store;

    // input transfer and key normalisation
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_len_in   = i_s_tdata[IN_LEN_LSB +: LEN_FIELD_W];
    assign w_len_sat  = (w_len_in > LEN_FIELD_W'(MAX_KEY_CHARS)) ?
                        LEN_FIELD_W'(MAX_KEY_CHARS) : w_len_in;
    assign w_len      = LEN_W'(w_len_sat);

    // bytes past the length are cleared
    always_comb begin
        for (int b = 0; b < MAX_KEY_CHARS; b++) begin
            w_key[b*CHAR_W +: CHAR_W] = (LEN_FIELD_W'(b) < w_len_sat) ?
                i_s_tdata[IN_KEY_LSB + b*CHAR_W +: CHAR_W] : '0;
        end
    end

    // hash unit
    hsif_hash #(
        .BUCKETS       (BUCKETS),
        .MAX_KEY_CHARS (MAX_KEY_CHARS)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_chars  (w_key),
        .i_len    (w_len),
        .o_done   (w_hash_done),
        .o_bucket (w_hash_bucket)
    );

    // bucket table: one row per bucket, each way {valid, length, key}
    hsif_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_hash_bucket),
        .o_rd_data (w_rd_data)
    );

    assign w_row = w_rd_data;

    // compare every valid way and pick the lowest free one
    always_comb begin
        logic taken;
        taken = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            w_hit[w] = w_row[w][WAY_W-1] &&
                       (w_row[w][KEY_W +: LEN_W] == r_len) &&
                       (w_row[w][KEY_W-1:0] == r_key);
            w_free_oh[w] = !w_row[w][WAY_W-1] && !taken;
            taken = taken || !w_row[w][WAY_W-1];
        end
    end

    assign w_found    = |w_hit;
    assign w_has_free = |w_free_oh;
    assign w_store    = (r_state == S_CHECK) && (r_cmd == OP_INSERT) &&
                        !w_found && w_has_free;

    // write-back row with the new key placed in the free way
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            w_new_row[w] = w_free_oh[w] ? {1'b1, r_len, r_key} : w_row[w];
        end
    end

    // ram port control: bucket read, clearing pass or insert write-back
    assign w_rd_en   = (r_state == S_HASH) && w_hash_done;
    assign w_wr_en   = (r_state == S_CLEAR) || w_store;
    assign w_wr_addr = (r_state == S_CLEAR) ? r_clr_addr : r_bucket;
    assign w_wr_data = (r_state == S_CLEAR) ? '0 : ROW_W'(w_new_row);

    // command sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            // output transfer empties the register unless a new result lands
            if (r_m_valid && i_m_tready && (r_state != S_OUT)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + BUCKET_W'(1);
                    if (r_clr_addr == BUCKET_W'(BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= i_s_tuser;
                        r_key   <= w_key;
                        r_len   <= w_len;
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (w_hash_done) begin
                        r_bucket <= w_hash_bucket;
                        r_state  <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_res_found <= w_found;
                    r_res_full  <= (r_cmd == OP_INSERT) && !w_found && !w_has_free;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_found <= r_res_found;
                        r_m_full  <= r_res_full;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result stream
    always_comb begin
        o_m_tdata                = '0;
        o_m_tdata[OUT_FOUND_BIT] = r_m_found;
        o_m_tdata[OUT_FULL_BIT]  = r_m_full;
    end
    assign o_m_tvalid = r_m_valid;

    // checks
    `HSIF_ASSERT(a_hash_done_when_waiting, i_clk, i_rst_n,
        w_hash_done |-> (r_state == S_HASH), "hash result arrived outside the hash wait")
    `HSIF_ASSERT(a_write_source, i_clk, i_rst_n,
        w_wr_en |-> ((r_state == S_CLEAR) || ((r_state == S_CHECK) && (r_cmd == OP_INSERT))),
        "table written outside clearing or insert")
    `HSIF_ASSERT_NEVER(a_found_and_full, i_clk, i_rst_n,
        o_m_tvalid && r_m_found && r_m_full, "result flags both found and bucket full")

endmodule
